// ===== rtl/kcl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

   localparam int KEY_W      = 4;
   localparam int PASSWORD_W = 20;
   localparam int DEBOUNCE_W = 8;
   localparam int DIGITS_W   = 3;

   localparam logic [KEY_W-1:0]      DIGIT_MAX    = 4'd9;
   localparam logic [KEY_W-1:0]      KEY_BACK     = 4'd10;
   localparam logic [KEY_W-1:0]      KEY_NONE     = 4'd11;
   localparam logic [DEBOUNCE_W-1:0] STABLE_MAX   = 8'd255;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd2;

   typedef enum logic [0:0] {
      CSR_PASSWORD = 1'b0,
      CSR_DEBOUNCE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_DIGIT  = 3'd1,
      EV_EXIT   = 3'd2,
      EV_WRONG  = 3'd3,
      EV_UNLOCK = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      BEEP_NONE   = 2'd0,
      BEEP_SHORT  = 2'd1,
      BEEP_DOUBLE = 2'd2
   } beep_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } key_type;

   typedef struct packed {
      event_type           event_code;
      beep_type            beep_code;
      logic [DIGITS_W-1:0] digits_entered;
      logic                is_unlocked;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/kcl_debounce.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kcl_debounce (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              step,
   input  wire                              freeze,
   input  wire  [kcl_pkg::KEY_W-1:0]        key,
   input  wire  [kcl_pkg::DEBOUNCE_W-1:0]   debounce_ticks,
   output kcl_pkg::key_type                 acc
);

   logic [kcl_pkg::KEY_W-1:0]      prev_ff, prev_in;
   logic [kcl_pkg::DEBOUNCE_W-1:0] stab_ff, stab_in;
   logic [kcl_pkg::DEBOUNCE_W-1:0] stab_inc;

   always_comb begin
      prev_in   = prev_ff;
      stab_in   = stab_ff;
      stab_inc  = stab_ff + 8'd1;
      acc.valid = 1'b0;
      acc.key   = key;
      if (step && !freeze) begin
         if (key == prev_ff) begin
            if (stab_ff != kcl_pkg::STABLE_MAX) begin
               stab_in   = stab_inc;
               acc.valid = (stab_inc == debounce_ticks);
            end
         end else begin
            prev_in = key;
            stab_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= kcl_pkg::KEY_NONE;
         stab_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         stab_ff <= stab_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/kcl_entry.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kcl_entry #(
   parameter int CODE_DIGITS = 6
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              step,
   input  wire  kcl_pkg::key_type           acc,
   input  wire  [kcl_pkg::PASSWORD_W-1:0]   password,
   output kcl_pkg::result_type              res,
   output logic                             unlocked
);

   localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam int VAL_W = 4 * CODE_DIGITS;
   localparam int CMP_W = (VAL_W > kcl_pkg::PASSWORD_W) ? VAL_W : kcl_pkg::PASSWORD_W;

   // prefix value of the first k digits held at entry k
   logic [VAL_W-1:0] pre_ff [CODE_DIGITS];
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             unlk_ff, unlk_in;

   logic [VAL_W-1:0] cur_val;
   logic [VAL_W-1:0] ext_val;
   logic [IDX_W-1:0] cnt_inc;
   logic [IDX_W+2:0] cnt_ext;
   logic             last;
   logic             match;
   logic             pre_we;

   assign cur_val  = (cnt_ff == '0) ? '0 : pre_ff[cnt_ff];
   assign ext_val  = (cur_val << 3) + (cur_val << 1) + VAL_W'(acc.key);
   assign cnt_inc  = cnt_ff + 1'b1;
   assign last     = (cnt_ff == IDX_W'(CODE_DIGITS - 1));
   assign match    = (CMP_W'(ext_val) == CMP_W'(password));
   assign cnt_ext  = {3'b000, cnt_in};
   assign unlocked = unlk_ff;

   always_comb begin
      cnt_in         = cnt_ff;
      unlk_in        = unlk_ff;
      pre_we         = 1'b0;
      res.event_code = kcl_pkg::EV_NONE;
      res.beep_code  = kcl_pkg::BEEP_NONE;
      if (step && !unlk_ff && acc.valid) begin
         if (acc.key <= kcl_pkg::DIGIT_MAX) begin
            if (last) begin
               cnt_in = '0;
               if (match) begin
                  unlk_in        = 1'b1;
                  res.event_code = kcl_pkg::EV_UNLOCK;
                  res.beep_code  = kcl_pkg::BEEP_SHORT;
               end else begin
                  res.event_code = kcl_pkg::EV_WRONG;
                  res.beep_code  = kcl_pkg::BEEP_DOUBLE;
               end
            end else begin
               cnt_in         = cnt_inc;
               pre_we         = 1'b1;
               res.event_code = kcl_pkg::EV_DIGIT;
               res.beep_code  = kcl_pkg::BEEP_SHORT;
            end
         end else if (acc.key == kcl_pkg::KEY_BACK) begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end
            res.event_code = kcl_pkg::EV_EXIT;
            res.beep_code  = kcl_pkg::BEEP_SHORT;
         end
      end
      res.digits_entered = cnt_ext[2:0];
      res.is_unlocked    = unlk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         unlk_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         unlk_ff <= unlk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pre_we) begin
         pre_ff[cnt_inc] <= ext_val;
      end
   end

   a_unlock_sticky: assert property (@(posedge clock) disable iff (reset)
      unlk_ff |=> unlk_ff)
      else $error("unlock flag dropped");

   a_quiet_unlocked: assert property (@(posedge clock) disable iff (reset)
      (step && unlk_ff) |-> (res.event_code == kcl_pkg::EV_NONE &&
                             res.beep_code == kcl_pkg::BEEP_NONE))
      else $error("event reported after unlock");

   a_unlock_event: assert property (@(posedge clock) disable iff (reset)
      (res.event_code == kcl_pkg::EV_UNLOCK) |=> (unlk_ff && cnt_ff == '0))
      else $error("unlock event without unlock state");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= IDX_W'(CODE_DIGITS - 1))
      else $error("digit count out of range");

endmodule

`default_nettype wire

// ===== rtl/debounced_keypad_code_lock.sv =====
// Request path: the input register loads on the request transaction, and the result
//   register loads from it once the response register is free or being accepted.
// Throughput: one tick per cycle while rsp_tready stays high; the response register frees
//   while the next tick sits in the input register.
// Reset: synchronous, active high; clears pipeline valids, debounce and entry
//   state, and loads password 0 and debounce length 2.
`timescale 1ns / 1ps
`default_nettype none

module debounced_keypad_code_lock #(
   parameter int CODE_DIGITS = 6
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [7:0]                      req_tdata,  // [3:0] key_sample
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [15:0]                     rsp_tdata,  // [2:0] event_code, [4:3] beep_code,
                                                       // [7:5] digits_entered, [8] is_unlocked
   input  wire                             csr_we,
   input  wire  [0:0]                      csr_addr,
   input  wire  [kcl_pkg::PASSWORD_W-1:0]  csr_wdata
);

   logic [kcl_pkg::PASSWORD_W-1:0] pw_ff;
   logic [kcl_pkg::DEBOUNCE_W-1:0] dbn_ff;

   logic                           in_vld_ff, in_vld_in;
   logic [kcl_pkg::KEY_W-1:0]      key_ff;
   logic                           out_vld_ff, out_vld_in;
   kcl_pkg::result_type            out_ff;

   logic                           step;
   logic                           unlocked;
   kcl_pkg::key_type               acc;
   kcl_pkg::result_type            res;

   assign step       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || step;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'b0000000, out_ff.is_unlocked, out_ff.digits_entered,
                        out_ff.beep_code, out_ff.event_code};

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tready) begin
         in_vld_in = req_tvalid;
      end
      out_vld_in = out_vld_ff;
      if (step) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         pw_ff      <= '0;
         dbn_ff     <= kcl_pkg::DEBOUNCE_RST;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_we) begin
            case (csr_addr)
               kcl_pkg::CSR_PASSWORD: pw_ff  <= csr_wdata;
               kcl_pkg::CSR_DEBOUNCE: dbn_ff <= csr_wdata[kcl_pkg::DEBOUNCE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         key_ff <= req_tdata[kcl_pkg::KEY_W-1:0];
      end
      if (step) begin
         out_ff <= res;
      end
   end

   kcl_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .freeze         (unlocked),
      .key            (key_ff),
      .debounce_ticks (dbn_ff),
      .acc            (acc)
   );

   kcl_entry #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_entry (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .acc      (acc),
      .password (pw_ff),
      .res      (res),
      .unlocked (unlocked)
   );

endmodule

`default_nettype wire

// ===== tb/debounced_keypad_code_lock_test.sv =====
`timescale 1ns / 1ps

module debounced_keypad_code_lock_test;

   localparam int CODE_DIGITS = 6;
   localparam int QUIET_LIMIT = 500;
   localparam logic [kcl_pkg::KEY_W-1:0] DIGIT_EMPTY = 4'd10;

   typedef struct packed {
      logic                         is_csr;
      logic [7:0]                   value;
      logic                         typed;
      kcl_pkg::event_type           ev;
      kcl_pkg::beep_type            bp;
      logic [kcl_pkg::DIGITS_W-1:0] held;
   } entry_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [7:0]                     req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [15:0]                    rsp_tdata;
   logic                           csr_we;
   kcl_pkg::csr_index_type         csr_addr;
   logic [kcl_pkg::PASSWORD_W-1:0] csr_wdata;

   logic [kcl_pkg::PASSWORD_W-1:0] pw_reg;
   logic [kcl_pkg::DEBOUNCE_W-1:0] db_reg;
   logic [kcl_pkg::KEY_W-1:0]      digit_buf [CODE_DIGITS];
   logic [kcl_pkg::DIGITS_W-1:0]   held_count;
   logic [kcl_pkg::KEY_W-1:0]      last_key;
   logic [kcl_pkg::DEBOUNCE_W-1:0] stable_run;
   logic                           open_flag;

   kcl_pkg::result_type pending_reports [$];
   entry_row_type       directed_rows [25];
   int                  failures = 0;
   int                  items_sent = 0;
   int                  quiet_cycles = 0;
   bit                  steady = 0;

   debounced_keypad_code_lock uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic clear_lock_state();
      int i;
      for (i = 0; i < CODE_DIGITS; i++) digit_buf[i] = DIGIT_EMPTY;
   endtask

   task automatic lock_tick(input logic [kcl_pkg::KEY_W-1:0] key,
                            output kcl_pkg::result_type res);
      logic    fire;
      longint  code;
      int      i;
      fire = 1'b0;
      res.event_code = kcl_pkg::EV_NONE;
      res.beep_code = kcl_pkg::BEEP_NONE;
      if (!open_flag) begin
         if (key == last_key) begin
            if (stable_run != kcl_pkg::STABLE_MAX) begin
               stable_run++;
               fire = (stable_run == db_reg);
            end
         end else begin
            last_key = key;
            stable_run = '0;
         end
         if (fire) begin
            if (key <= kcl_pkg::DIGIT_MAX) begin
               if (held_count < CODE_DIGITS) begin
                  digit_buf[held_count] = key;
                  held_count++;
               end
               if (held_count < CODE_DIGITS) begin
                  res.event_code = kcl_pkg::EV_DIGIT;
                  res.beep_code = kcl_pkg::BEEP_SHORT;
               end else begin
                  held_count = '0;
                  code = 0;
                  for (i = 0; i < CODE_DIGITS; i++) code = code * 10 + (digit_buf[i] % 10);
                  if (code == longint'(pw_reg)) begin
                     open_flag = 1'b1;
                     res.event_code = kcl_pkg::EV_UNLOCK;
                     res.beep_code = kcl_pkg::BEEP_SHORT;
                  end else begin
                     clear_lock_state();
                     res.event_code = kcl_pkg::EV_WRONG;
                     res.beep_code = kcl_pkg::BEEP_DOUBLE;
                  end
               end
            end else if (key == kcl_pkg::KEY_BACK) begin
               if (held_count > 0) begin
                  held_count--;
                  digit_buf[held_count] = DIGIT_EMPTY;
               end
               res.event_code = kcl_pkg::EV_EXIT;
               res.beep_code = kcl_pkg::BEEP_SHORT;
            end
         end
      end
      res.digits_entered = held_count;
      res.is_unlocked = open_flag;
   endtask

   task automatic send_key(input logic [kcl_pkg::KEY_W-1:0] key, input bit use_typed = 1'b0,
                           input kcl_pkg::result_type typed_res = '0);
      kcl_pkg::result_type res;
      @(negedge clock);
      while (!steady && $urandom_range(99) < 17) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {4'b0, key};
      do @(posedge clock); while (!req_tready);
      lock_tick(key, res);
      pending_reports.push_back(use_typed ? typed_res : res);
      items_sent++;
   endtask

   task automatic press_key(input logic [kcl_pkg::KEY_W-1:0] key, input int hold);
      repeat (hold) send_key(key);
      repeat ($urandom_range(2, 1)) send_key(kcl_pkg::KEY_NONE);
   endtask

   task automatic set_lock_config(input logic [kcl_pkg::PASSWORD_W-1:0] pw,
                                  input logic [kcl_pkg::DEBOUNCE_W-1:0] db);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = kcl_pkg::CSR_PASSWORD;
      csr_wdata = pw;
      pw_reg = pw;
      @(negedge clock);
      csr_addr = kcl_pkg::CSR_DEBOUNCE;
      csr_wdata = {{(kcl_pkg::PASSWORD_W-kcl_pkg::DEBOUNCE_W){1'b0}}, db};
      db_reg = db;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic lock_traffic(input int n);
      int stop;
      int pick;
      int hold;
      stop = items_sent + n;
      while (items_sent < stop) begin
         pick = $urandom_range(99);
         hold = int'(db_reg) + 1 + $urandom_range(2);
         if (pick < 60)
            press_key(4'($urandom_range(9)), hold);
         else if (pick < 72)
            press_key(kcl_pkg::KEY_BACK, hold);
         else if (pick < 80)
            press_key(4'($urandom_range(15, 11)), hold);
         else if (pick < 90 && db_reg > 1)
            press_key(4'($urandom_range(9)), $urandom_range(int'(db_reg), 1));
         else
            send_key(4'($urandom()));
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = steady || ($urandom_range(99) >= 17);
      end
   end

   always @(posedge clock) begin
      kcl_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected response transaction: rsp_tdata %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[2:0] !== want.event_code) begin
               $error("event_code: expected %0d, actual %0d", want.event_code, rsp_tdata[2:0]);
               failures++;
            end
            if (rsp_tdata[4:3] !== want.beep_code) begin
               $error("beep_code: expected %0d, actual %0d", want.beep_code, rsp_tdata[4:3]);
               failures++;
            end
            if (rsp_tdata[7:5] !== want.digits_entered) begin
               $error("digits_entered: expected %0d, actual %0d",
                      want.digits_entered, rsp_tdata[7:5]);
               failures++;
            end
            if (rsp_tdata[8] !== want.is_unlocked) begin
               $error("is_unlocked: expected %0d, actual %0d", want.is_unlocked, rsp_tdata[8]);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int  r;
      int  i;
      longint scale;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = kcl_pkg::CSR_PASSWORD;
      csr_wdata = '0;
      pw_reg = '0;
      db_reg = kcl_pkg::DEBOUNCE_RST;
      clear_lock_state();
      held_count = '0;
      last_key = kcl_pkg::KEY_NONE;
      stable_run = '0;
      open_flag = 1'b0;

      directed_rows = '{
         '{1'b0, 8'd15, 1'b1, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd15, 1'b1, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd15, 1'b1, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd0,  1'b1, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd0,  1'b1, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd0,  1'b1, kcl_pkg::EV_DIGIT, kcl_pkg::BEEP_SHORT,  3'd1},
         '{1'b0, 8'd10, 1'b1, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd1},
         '{1'b0, 8'd10, 1'b1, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd1},
         '{1'b0, 8'd10, 1'b1, kcl_pkg::EV_EXIT,  kcl_pkg::BEEP_SHORT,  3'd0},
         '{1'b1, 8'd1,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd11, 1'b1, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd10, 1'b1, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd10, 1'b1, kcl_pkg::EV_EXIT,  kcl_pkg::BEEP_SHORT,  3'd0},
         '{1'b0, 8'd9,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd9,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd8,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd8,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd7,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd7,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd6,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd6,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd5,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd5,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd4,  1'b0, kcl_pkg::EV_NONE,  kcl_pkg::BEEP_NONE,   3'd0},
         '{1'b0, 8'd4,  1'b1, kcl_pkg::EV_WRONG, kcl_pkg::BEEP_DOUBLE, 3'd0}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (r = 0; r < 25; r++) begin
         if (directed_rows[r].is_csr)
            set_lock_config(pw_reg, directed_rows[r].value);
         else
            send_key(directed_rows[r].value[kcl_pkg::KEY_W-1:0], directed_rows[r].typed,
                     '{directed_rows[r].ev, directed_rows[r].bp, directed_rows[r].held, 1'b0});
      end

      set_lock_config(20'hFFFFF, 8'd1);
      lock_traffic(100);

      set_lock_config(20'd0, 8'd3);
      steady = 1'b1;
      lock_traffic(100);
      steady = 1'b0;

      set_lock_config(20'($urandom_range(999999)), 8'd0);
      lock_traffic(60);

      set_lock_config(20'd999999, kcl_pkg::STABLE_MAX);
      press_key(4'($urandom_range(9)), 256 + $urandom_range(20));
      press_key(kcl_pkg::KEY_BACK, 256 + $urandom_range(20));

      set_lock_config(20'($urandom_range(999999)), 8'($urandom_range(5, 1)));
      lock_traffic(150);

      // clear any partial entry, then key in the stored code
      set_lock_config(20'($urandom_range(999999)), 8'd2);
      send_key(kcl_pkg::KEY_NONE);
      repeat (CODE_DIGITS) press_key(kcl_pkg::KEY_BACK, 3);
      scale = 100000;
      for (i = 0; i < CODE_DIGITS; i++) begin
         press_key(4'((longint'(pw_reg) / scale) % 10), 3 + $urandom_range(1));
         scale = scale / 10;
      end
      lock_traffic(40);

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("responses never received: %0d", pending_reports.size());
         failures++;
      end
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
